// ===== rtl/hgss_pkg.sv =====
// Shared types and constants of the Helmholtz Gauss-Seidel solver.
`default_nettype none
package hgss_pkg;

   localparam int VAL_W  = 40;
   localparam int IDX_W  = 12;
   localparam int DIM_W  = 13;
   localparam int ITER_W = 16;
   localparam int COEF_W = 40;
   localparam int INVD_W = 32;
   localparam int SUM_W  = 63;
   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;

   // operation codes
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_RUN  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // result kinds
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_RUN  = 1'b1;

   // register indexes
   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_ITERS  = 3'd2;
   localparam logic [2:0] REG_IHX    = 3'd3;
   localparam logic [2:0] REG_IHY    = 3'd4;
   localparam logic [2:0] REG_DIAG   = 3'd5;
   localparam logic [2:0] REG_INVD   = 3'd6;

   typedef struct packed {
      logic [1:0]              operation;
      logic [IDX_W-1:0]        point_index;
      logic signed [VAL_W-1:0] u_value;
      logic signed [VAL_W-1:0] f_value;
   } req_type;

   typedef struct packed {
      logic                    result_kind;
      logic signed [VAL_W-1:0] read_value;
      logic [SUM_W-1:0]        residual_sum;
      logic                    index_error;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0]  grid_width;
      logic [DIM_W-1:0]  grid_height;
      logic [ITER_W-1:0] iteration_count;
      logic [COEF_W-1:0] inv_hx_squared;
      logic [COEF_W-1:0] inv_hy_squared;
      logic [COEF_W-1:0] diagonal_coeff;
      logic [INVD_W-1:0] inv_diagonal_coeff;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic        shift32;
      logic [63:0] mag_a;
      logic [63:0] mag_b;
   } mul_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] mag;
   } mul_rsp_type;

   typedef enum logic [3:0] {
      ST_LIMIT,
      ST_IDLE,
      ST_READ,
      ST_RUN_START,
      ST_FETCH,
      ST_MUL,
      ST_MUL_WAIT,
      ST_WRITE,
      ST_NEXT,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/helmholtz_gauss_seidel_solver.sv =====
// Top level: sequencer and datapath of the Gauss-Seidel Helmholtz solver.
//
// Commands enter on req_data, taken when start is high and busy is low.
// A load writes u and f of one point; no result follows.
// A read returns the solution word through the ST_READ state and the result register, with
// index_error set when the index lies outside the grid.
// A run sweeps the interior points, each iteration as a residual pass and then
// an update pass. The point and its four neighbors come through the single read
// port of the grid memory, and each product goes through the shared multiplier.
// Results appear on rsp_data for one cycle with rsp_valid; the receiver
// cannot stall, and the block issues at most one result at a time.
// After reset and after every write of grid_width or grid_height, busy
// stays high while the usable row count and grid size are worked out.
// Grid memory contents are not cleared.
// Configuration is taken on the APB-style port at any time; write it only
// while no command is in flight.
`default_nettype none
module helmholtz_gauss_seidel_solver #(
   parameter int MAX_POINTS = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire hgss_pkg::req_type             req_data,
   output logic                               rsp_valid,
   output hgss_pkg::rsp_type                  rsp_data,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [hgss_pkg::CSR_AW-1:0]   paddr,
   input  wire logic [hgss_pkg::CSR_DW-1:0]   pwdata,
   output logic      [hgss_pkg::CSR_DW-1:0]   prdata,
   output logic                               pready
);

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int LIM_W  = $clog2(MAX_POINTS + (1 << hgss_pkg::DIM_W));
   localparam int RAM_W  = 2 * hgss_pkg::VAL_W;
   localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(MAX_POINTS);
   localparam logic signed [63:0] SAT_POS = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SAT_NEG = 64'sh8000_0000_0000_0001;
   localparam logic signed [63:0] VAL_MAX64 = 64'sd549755813887;
   localparam logic signed [63:0] VAL_MIN64 = -64'sd549755813888;

   // saturating add, symmetric range
   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (!s[64] && s[63]) begin
         return SAT_POS;
      end else if (s[64] && (!s[63] || s[62:0] == 63'd0)) begin
         return SAT_NEG;
      end else begin
         return s[63:0];
      end
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      return sat_add(a, -b);
   endfunction

   function automatic logic signed [63:0] sext_val(input logic signed [39:0] v);
      return {{24{v[39]}}, v};
   endfunction

   hgss_pkg::cfg_type     cfg;
   logic                  geom_wr;
   hgss_pkg::mul_req_type mul_req;
   hgss_pkg::mul_rsp_type mul_rsp;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [RAM_W-1:0]  ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [RAM_W-1:0]  ram_rdata;

   hgss_pkg::state_type state_ff, state_in;
   logic                      pend_ff, pend_in;
   logic [LIM_W-1:0]          lim_ff, lim_in;
   logic [hgss_pkg::DIM_W-1:0] rows_ff, rows_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   hgss_pkg::rsp_type         rsp_data_ff, rsp_data_in;
   logic                      bad_ff, bad_in;
   logic [hgss_pkg::ITER_W-1:0] it_ff, it_in;
   logic                      pass_ff, pass_in;
   logic [hgss_pkg::DIM_W-1:0] row_ff, row_in;
   logic [hgss_pkg::DIM_W-1:0] col_ff, col_in;
   logic [ADDR_W-1:0]         pt_ff, pt_in;
   logic [2:0]                fk_ff, fk_in;
   logic [1:0]                ph_ff, ph_in;
   logic signed [39:0]        u_n_ff, u_n_in, u_w_ff, u_w_in, u_c_ff, u_c_in;
   logic signed [39:0]        u_e_ff, u_e_in, u_s_ff, u_s_in, f_c_ff, f_c_in;
   logic signed [63:0]        t1_ff, t1_in, nb_ff, nb_in, d_ff, d_in;
   logic signed [39:0]        nu_ff, nu_in;
   logic [hgss_pkg::SUM_W-1:0] acc_ff, acc_in;
   logic                      sign_ff, sign_in;

   logic                      accept;
   logic                      lim_stop;
   logic [LIM_W-1:0]          lim_next;
   logic [ADDR_W-1:0]         w_a;
   logic [ADDR_W-1:0]         fetch_addr;
   logic [ADDR_W-1:0]         req_addr;
   logic                      no_work, last_col, last_row, last_iter, last_step;
   logic signed [40:0]        sx, sy;
   logic signed [63:0]        res, upd, x_op, prod_s, nu_sat;
   logic [63:0]               x_mag;
   logic [63:0]               acc_sum;

   hgss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .geom_wr (geom_wr)
   );

   hgss_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   hgss_ram #(.WIDTH(RAM_W), .DEPTH(MAX_POINTS)) u_grid (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // grid geometry and loop bounds
   assign accept    = start && !busy;
   assign req_addr  = ADDR_W'(req_data.point_index);
   assign lim_next  = lim_ff + LIM_W'(cfg.grid_width);
   assign lim_stop  = cfg.grid_width == '0 || rows_ff == cfg.grid_height ||
                      lim_next > LIM_MAX;
   assign w_a       = ADDR_W'(cfg.grid_width);
   assign no_work   = cfg.grid_width < 13'd3 || rows_ff < 13'd3 ||
                      cfg.iteration_count == '0;
   assign last_col  = col_ff == cfg.grid_width - 13'd2;
   assign last_row  = row_ff == rows_ff - 13'd2;
   assign last_iter = it_ff == cfg.iteration_count - 16'd1;
   assign last_step = last_col && last_row && pass_ff && last_iter;

   // stencil arithmetic
   always_comb begin
      sx     = {u_w_ff[39], u_w_ff} + {u_e_ff[39], u_e_ff};
      sy     = {u_n_ff[39], u_n_ff} + {u_s_ff[39], u_s_ff};
      res    = sat_sub(sext_val(f_c_ff), sat_sub(d_ff, nb_ff));
      upd    = sat_add(sext_val(f_c_ff), nb_ff);
      case (ph_ff)
         2'd0:    x_op = {{23{sx[40]}}, sx};
         2'd1:    x_op = {{23{sy[40]}}, sy};
         2'd2:    x_op = pass_ff ? upd : sext_val(u_c_ff);
         default: x_op = res;
      endcase
      x_mag  = x_op[63] ? 64'(-x_op) : 64'(x_op);
      prod_s = sign_ff ? -$signed({1'b0, mul_rsp.mag}) : $signed({1'b0, mul_rsp.mag});
      if (prod_s > VAL_MAX64) begin
         nu_sat = VAL_MAX64;
      end else if (prod_s < VAL_MIN64) begin
         nu_sat = VAL_MIN64;
      end else begin
         nu_sat = prod_s;
      end
      acc_sum = {1'b0, acc_ff} + {1'b0, mul_rsp.mag};
   end

   // neighbor fetch order: north, west, center, east, south
   always_comb begin
      case (fk_ff)
         3'd0:    fetch_addr = pt_ff - w_a;
         3'd1:    fetch_addr = pt_ff - ADDR_W'(1);
         3'd3:    fetch_addr = pt_ff + ADDR_W'(1);
         3'd4:    fetch_addr = pt_ff + w_a;
         default: fetch_addr = pt_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hgss_pkg::ST_LIMIT: begin
            if (lim_stop) state_in = hgss_pkg::ST_IDLE;
         end
         hgss_pkg::ST_IDLE: begin
            if (pend_ff) begin
               state_in = hgss_pkg::ST_LIMIT;
            end else if (accept && req_data.operation == hgss_pkg::OP_RUN) begin
               state_in = hgss_pkg::ST_RUN_START;
            end else if (accept && req_data.operation == hgss_pkg::OP_READ) begin
               state_in = hgss_pkg::ST_READ;
            end
         end
         hgss_pkg::ST_READ:      state_in = hgss_pkg::ST_IDLE;
         hgss_pkg::ST_RUN_START: begin
            state_in = no_work ? hgss_pkg::ST_DONE : hgss_pkg::ST_FETCH;
         end
         hgss_pkg::ST_FETCH: begin
            if (fk_ff == 3'd5) state_in = hgss_pkg::ST_MUL;
         end
         hgss_pkg::ST_MUL:       state_in = hgss_pkg::ST_MUL_WAIT;
         hgss_pkg::ST_MUL_WAIT: begin
            if (mul_rsp.done) begin
               if (!pass_ff && ph_ff == 2'd3) begin
                  state_in = hgss_pkg::ST_NEXT;
               end else if (pass_ff && ph_ff == 2'd2) begin
                  state_in = hgss_pkg::ST_WRITE;
               end else begin
                  state_in = hgss_pkg::ST_MUL;
               end
            end
         end
         hgss_pkg::ST_WRITE:     state_in = hgss_pkg::ST_NEXT;
         hgss_pkg::ST_NEXT: begin
            state_in = last_step ? hgss_pkg::ST_DONE : hgss_pkg::ST_FETCH;
         end
         hgss_pkg::ST_DONE:      state_in = hgss_pkg::ST_IDLE;
         default:                state_in = hgss_pkg::ST_IDLE;
      endcase
   end

   // outputs: handshake, memory and multiplier controls
   always_comb begin
      busy            = state_ff != hgss_pkg::ST_IDLE || pend_ff;
      ram_raddr       = (state_ff == hgss_pkg::ST_IDLE) ? req_addr : fetch_addr;
      ram_we          = 1'b0;
      ram_waddr       = req_addr;
      ram_wdata       = {req_data.u_value, req_data.f_value};
      mul_req.start   = state_ff == hgss_pkg::ST_MUL;
      mul_req.shift32 = pass_ff && ph_ff == 2'd2;
      mul_req.mag_a   = x_mag;
      case (ph_ff)
         2'd0:    mul_req.mag_b = 64'(cfg.inv_hx_squared);
         2'd1:    mul_req.mag_b = 64'(cfg.inv_hy_squared);
         2'd2:    mul_req.mag_b = pass_ff ? 64'(cfg.inv_diagonal_coeff)
                                          : 64'(cfg.diagonal_coeff);
         default: mul_req.mag_b = x_mag;
      endcase
      case (state_ff)
         hgss_pkg::ST_IDLE: begin
            ram_we = accept && req_data.operation == hgss_pkg::OP_LOAD &&
                     32'(req_data.point_index) < 32'(MAX_POINTS);
         end
         hgss_pkg::ST_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = pt_ff;
            ram_wdata = {nu_ff, f_c_ff};
         end
         default: ram_we = 1'b0;
      endcase
   end

   // datapath and loop counters
   always_comb begin
      pend_in      = pend_ff || geom_wr;
      lim_in       = lim_ff;
      rows_in      = rows_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      bad_in       = bad_ff;
      it_in        = it_ff;
      pass_in      = pass_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pt_in        = pt_ff;
      fk_in        = fk_ff;
      ph_in        = ph_ff;
      u_n_in       = u_n_ff;
      u_w_in       = u_w_ff;
      u_c_in       = u_c_ff;
      u_e_in       = u_e_ff;
      u_s_in       = u_s_ff;
      f_c_in       = f_c_ff;
      t1_in        = t1_ff;
      nb_in        = nb_ff;
      d_in         = d_ff;
      nu_in        = nu_ff;
      acc_in       = acc_ff;
      sign_in      = sign_ff;
      case (state_ff)
         hgss_pkg::ST_LIMIT: begin
            if (!lim_stop) begin
               lim_in  = lim_next;
               rows_in = rows_ff + 13'd1;
            end
         end
         hgss_pkg::ST_IDLE: begin
            if (pend_ff) begin
               // restart the row count for the new geometry
               pend_in = geom_wr;
               lim_in  = '0;
               rows_in = '0;
            end
            bad_in = 32'(req_data.point_index) >= 32'(lim_ff);
         end
         hgss_pkg::ST_READ: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.result_kind  = hgss_pkg::KIND_READ;
            rsp_data_in.read_value   = bad_ff ? '0 : ram_rdata[RAM_W-1:hgss_pkg::VAL_W];
            rsp_data_in.residual_sum = '0;
            rsp_data_in.index_error  = bad_ff;
         end
         hgss_pkg::ST_RUN_START: begin
            acc_in  = '0;
            it_in   = '0;
            pass_in = 1'b0;
            row_in  = 13'd1;
            col_in  = 13'd1;
            pt_in   = w_a + ADDR_W'(1);
            fk_in   = 3'd0;
         end
         hgss_pkg::ST_FETCH: begin
            fk_in = fk_ff + 3'd1;
            ph_in = 2'd0;
            case (fk_ff)
               3'd1: u_n_in = ram_rdata[RAM_W-1:hgss_pkg::VAL_W];
               3'd2: u_w_in = ram_rdata[RAM_W-1:hgss_pkg::VAL_W];
               3'd3: begin
                  u_c_in = ram_rdata[RAM_W-1:hgss_pkg::VAL_W];
                  f_c_in = ram_rdata[hgss_pkg::VAL_W-1:0];
               end
               3'd4: u_e_in = ram_rdata[RAM_W-1:hgss_pkg::VAL_W];
               3'd5: u_s_in = ram_rdata[RAM_W-1:hgss_pkg::VAL_W];
               default: fk_in = fk_ff + 3'd1;
            endcase
         end
         hgss_pkg::ST_MUL: begin
            sign_in = x_op[63];
         end
         hgss_pkg::ST_MUL_WAIT: begin
            if (mul_rsp.done) begin
               ph_in = ph_ff + 2'd1;
               case (ph_ff)
                  2'd0: t1_in = prod_s;
                  2'd1: nb_in = sat_add(t1_ff, prod_s);
                  2'd2: begin
                     if (pass_ff) nu_in = nu_sat[39:0];
                     else d_in = prod_s;
                  end
                  default: begin
                     // accumulate the squared residual, saturating
                     acc_in = acc_sum[63] ? '1 : acc_sum[62:0];
                  end
               endcase
            end
         end
         hgss_pkg::ST_NEXT: begin
            fk_in = 3'd0;
            if (last_col && last_row) begin
               row_in = 13'd1;
               col_in = 13'd1;
               pt_in  = w_a + ADDR_W'(1);
               if (!pass_ff) begin
                  pass_in = 1'b1;
               end else if (!last_iter) begin
                  pass_in = 1'b0;
                  it_in   = it_ff + 16'd1;
                  acc_in  = '0;
               end
            end else if (last_col) begin
               row_in = row_ff + 13'd1;
               col_in = 13'd1;
               pt_in  = pt_ff + ADDR_W'(3);
            end else begin
               col_in = col_ff + 13'd1;
               pt_in  = pt_ff + ADDR_W'(1);
            end
         end
         hgss_pkg::ST_DONE: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.result_kind  = hgss_pkg::KIND_RUN;
            rsp_data_in.read_value   = '0;
            rsp_data_in.residual_sum = acc_ff;
            rsp_data_in.index_error  = 1'b0;
         end
         default: rsp_valid_in = 1'b0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hgss_pkg::ST_LIMIT;
         pend_ff      <= 1'b0;
         lim_ff       <= '0;
         rows_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         it_ff        <= '0;
         pass_ff      <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         pt_ff        <= '0;
         fk_ff        <= '0;
         ph_ff        <= '0;
         acc_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         lim_ff       <= lim_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
         it_ff        <= it_in;
         pass_ff      <= pass_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         pt_ff        <= pt_in;
         fk_ff        <= fk_in;
         ph_ff        <= ph_in;
         acc_ff       <= acc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      bad_ff      <= bad_in;
      u_n_ff      <= u_n_in;
      u_w_ff      <= u_w_in;
      u_c_ff      <= u_c_in;
      u_e_ff      <= u_e_in;
      u_s_ff      <= u_s_in;
      f_c_ff      <= f_c_in;
      t1_ff       <= t1_in;
      nb_ff       <= nb_in;
      d_ff        <= d_in;
      nu_ff       <= nu_in;
      sign_ff     <= sign_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // a result only follows a read or the end of a run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == hgss_pkg::ST_READ ||
                             state_ff == hgss_pkg::ST_DONE))
      else $error("result word without a finished command");

   // results are single-cycle strobes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held longer than one cycle");

   // the multiplier only answers while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> state_ff == hgss_pkg::ST_MUL_WAIT)
      else $error("multiplier result outside its wait state");

   // no grid write while a stencil fetch is in progress
   assert property (@(posedge clock) disable iff (reset)
      state_ff == hgss_pkg::ST_FETCH |-> !ram_we)
      else $error("grid write during neighbor fetch");
`endif

endmodule
`default_nettype wire

// ===== rtl/hgss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module hgss_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port, old data on a same-address write
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/hgss_mul.sv =====
// Iterative 64x64 magnitude multiplier with rounding shift and saturation.
`default_nettype none
module hgss_mul (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hgss_pkg::mul_req_type req,
   output hgss_pkg::mul_rsp_type      rsp
);

   logic                          act_ff, act_in;
   logic [2:0]                    cnt_ff, cnt_in;
   logic [63:0]                   a_ff, a_in;
   logic [63:0]                   b_ff, b_in;
   logic                          sh32_ff, sh32_in;
   logic [127:0]                  acc_ff, acc_in;
   logic                          done_ff, done_in;
   logic [hgss_pkg::SUM_W-1:0]    mag_ff, mag_in;

   logic [31:0]  part_a;
   logic [31:0]  part_b;
   logic [63:0]  part_prod;
   logic [127:0] part_shifted;
   logic [127:0] round_sum;
   logic [127:0] round_shifted;

   // pick one 32x32 partial product per cycle
   always_comb begin
      part_a    = cnt_ff[0] ? a_ff[63:32] : a_ff[31:0];
      part_b    = cnt_ff[1] ? b_ff[63:32] : b_ff[31:0];
      part_prod = part_a * part_b;
      case (cnt_ff[1:0])
         2'd0:    part_shifted = {64'd0, part_prod};
         2'd3:    part_shifted = {part_prod, 64'd0};
         default: part_shifted = {32'd0, part_prod, 32'd0};
      endcase
   end

   // round half away from zero on the magnitude, then shift
   always_comb begin
      round_sum     = acc_ff + (sh32_ff ? (128'd1 << 31) : (128'd1 << 15));
      round_shifted = sh32_ff ? (round_sum >> 32) : (round_sum >> 16);
   end

   // sequence the partial products and the finishing step
   always_comb begin
      act_in  = act_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      sh32_in = sh32_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      mag_in  = mag_ff;
      if (req.start) begin
         act_in  = 1'b1;
         cnt_in  = 3'd0;
         a_in    = req.mag_a;
         b_in    = req.mag_b;
         sh32_in = req.shift32;
         acc_in  = '0;
      end else if (act_ff) begin
         if (cnt_ff == 3'd4) begin
            act_in  = 1'b0;
            done_in = 1'b1;
            if (|round_shifted[127:63]) begin
               mag_in = '1;
            end else begin
               mag_in = round_shifted[62:0];
            end
         end else begin
            acc_in = acc_ff + part_shifted;
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         act_ff  <= act_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      sh32_ff <= sh32_in;
      acc_ff  <= acc_in;
      mag_ff  <= mag_in;
   end

   assign rsp.done = done_ff;
   assign rsp.mag  = mag_ff;

endmodule
`default_nettype wire

// ===== rtl/hgss_csr.sv =====
// APB-style configuration registers of the solver.
`default_nettype none
module hgss_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [hgss_pkg::CSR_AW-1:0]   paddr,
   input  wire logic [hgss_pkg::CSR_DW-1:0]   pwdata,
   output logic      [hgss_pkg::CSR_DW-1:0]   prdata,
   output logic                               pready,
   output hgss_pkg::cfg_type                  cfg,
   output logic                               geom_wr
);

   hgss_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [2:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[5:3];
   assign geom_wr = wr_en && (reg_idx == hgss_pkg::REG_WIDTH ||
                              reg_idx == hgss_pkg::REG_HEIGHT);

   // decode the write word
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            hgss_pkg::REG_WIDTH:  cfg_in.grid_width         = pwdata[12:0];
            hgss_pkg::REG_HEIGHT: cfg_in.grid_height        = pwdata[12:0];
            hgss_pkg::REG_ITERS:  cfg_in.iteration_count    = pwdata[15:0];
            hgss_pkg::REG_IHX:    cfg_in.inv_hx_squared     = pwdata[39:0];
            hgss_pkg::REG_IHY:    cfg_in.inv_hy_squared     = pwdata[39:0];
            hgss_pkg::REG_DIAG:   cfg_in.diagonal_coeff     = pwdata[39:0];
            hgss_pkg::REG_INVD:   cfg_in.inv_diagonal_coeff = pwdata[31:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width         <= 13'd64;
         cfg_ff.grid_height        <= 13'd64;
         cfg_ff.iteration_count    <= 16'd1;
         cfg_ff.inv_hx_squared     <= '0;
         cfg_ff.inv_hy_squared     <= '0;
         cfg_ff.diagonal_coeff     <= '0;
         cfg_ff.inv_diagonal_coeff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         hgss_pkg::REG_WIDTH:  prdata = 64'(cfg_ff.grid_width);
         hgss_pkg::REG_HEIGHT: prdata = 64'(cfg_ff.grid_height);
         hgss_pkg::REG_ITERS:  prdata = 64'(cfg_ff.iteration_count);
         hgss_pkg::REG_IHX:    prdata = 64'(cfg_ff.inv_hx_squared);
         hgss_pkg::REG_IHY:    prdata = 64'(cfg_ff.inv_hy_squared);
         hgss_pkg::REG_DIAG:   prdata = 64'(cfg_ff.diagonal_coeff);
         hgss_pkg::REG_INVD:   prdata = 64'(cfg_ff.inv_diagonal_coeff);
         default:              prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the Helmholtz Gauss-Seidel solver.
`timescale 1ns / 100ps
module tb;

   localparam int STORE = 4096;
   localparam int IDX_BITS = hgss_pkg::IDX_W;
   localparam int VAL_BITS = hgss_pkg::VAL_W;
   localparam int ADR_BITS = hgss_pkg::CSR_AW;
   localparam longint SAT = 64'sh7fff_ffff_ffff_ffff;
   localparam longint VMAX = (64'sd1 <<< 39) - 1;
   localparam longint VMIN = -(64'sd1 <<< 39);
   // operation code that the block ignores
   localparam logic [1:0] OP_NONE = 2'd3;

   logic clock, reset, start, busy, rsp_valid;
   hgss_pkg::req_type req_data;
   hgss_pkg::rsp_type rsp_data;
   logic psel, penable, pwrite, pready;
   logic [hgss_pkg::CSR_AW-1:0] paddr;
   logic [hgss_pkg::CSR_DW-1:0] pwdata, prdata;

   helmholtz_gauss_seidel_solver dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // shadow of the grids and the registers
   longint sol_grid [STORE];
   longint src_grid [STORE];
   bit     loaded [STORE];
   longint unsigned resid_acc;
   logic [hgss_pkg::DIM_W-1:0] width_q, height_q;
   logic [hgss_pkg::ITER_W-1:0] iters_q;
   longint unsigned ihx_q, ihy_q, diag_q, invd_q;

   hgss_pkg::rsp_type pending_rsp[$];
   int errors, sent, burst_left;

   typedef struct {
      logic [1:0] op;
      int idx;
      longint u, f;
      bit typed;
      longint rd;
   } row_type;

   typedef struct {
      int w, h, it;
      longint unsigned ihx, ihy, diag, invd;
      bit full_load;
   } phase_type;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #500ms;
      $display("status: fail");
      $finish;
   end

   // rounded, saturated magnitude product
   function automatic longint unsigned scale_mag(longint unsigned m, longint unsigned c,
                                                  int sh);
      logic [127:0] p;
      p = {64'd0, m} * {64'd0, c};
      p = p + (128'd1 << (sh - 1));
      p = p >> sh;
      if (p > 128'(SAT)) return SAT;
      return p[63:0];
   endfunction

   function automatic longint scale_signed(longint x, longint unsigned c, int sh);
      longint unsigned r;
      r = scale_mag(x < 0 ? -x : x, c, sh);
      return x < 0 ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint clamp_add(longint a, longint b);
      logic signed [64:0] s;
      s = a;
      s = s + b;
      if (s > SAT) return SAT;
      if (s < -SAT) return -SAT;
      return s[63:0];
   endfunction

   function automatic longint stencil_flux(int i, int w);
      return clamp_add(scale_signed(sol_grid[i-1] + sol_grid[i+1], ihx_q, 16),
                       scale_signed(sol_grid[i-w] + sol_grid[i+w], ihy_q, 16));
   endfunction

   function automatic int rows_in_use();
      if (width_q == 0) return 0;
      return (height_q < STORE / width_q) ? height_q : STORE / width_q;
   endfunction

   // one run: residual pass then in-place sweep, per iteration
   function automatic void relax_grid();
      int w, h, i;
      longint res, nu;
      longint unsigned sq;
      w = width_q;
      h = rows_in_use();
      resid_acc = 0;
      if (w < 3 || h < 3) return;
      for (int it = 0; it < iters_q; it++) begin
         resid_acc = 0;
         for (int r = 1; r + 1 < h; r++)
            for (int c = 1; c + 1 < w; c++) begin
               i = r * w + c;
               res = clamp_add(src_grid[i], -clamp_add(scale_signed(sol_grid[i], diag_q, 16),
                                                       -stencil_flux(i, w)));
               sq = scale_mag(res < 0 ? -res : res, res < 0 ? -res : res, 16);
               if (resid_acc > SAT - sq) resid_acc = SAT;
               else resid_acc += sq;
            end
         for (int r = 1; r + 1 < h; r++)
            for (int c = 1; c + 1 < w; c++) begin
               i = r * w + c;
               nu = scale_signed(clamp_add(src_grid[i], stencil_flux(i, w)), invd_q, 32);
               if (nu > VMAX) nu = VMAX;
               if (nu < VMIN) nu = VMIN;
               sol_grid[i] = nu;
            end
      end
   endfunction

   // append one expected result word
   function automatic void queue_word(hgss_pkg::rsp_type e);
      pending_rsp.insert(pending_rsp.size(), e);
   endfunction

   function automatic void predict_word(hgss_pkg::req_type c, bit typed, longint rd);
      hgss_pkg::rsp_type e;
      int size;
      e = '0;
      size = width_q * rows_in_use();
      case (c.operation)
         hgss_pkg::OP_LOAD: begin
            sol_grid[c.point_index] = c.u_value;
            src_grid[c.point_index] = c.f_value;
            loaded[c.point_index] = 1;
         end
         hgss_pkg::OP_RUN: begin
            relax_grid();
            e.result_kind = hgss_pkg::KIND_RUN;
            e.residual_sum = resid_acc[hgss_pkg::SUM_W-1:0];
            queue_word(e);
         end
         hgss_pkg::OP_READ: begin
            e.result_kind = hgss_pkg::KIND_READ;
            e.index_error = c.point_index >= size;
            if (typed) e.read_value = rd[hgss_pkg::VAL_W-1:0];
            else if (!e.index_error)
               e.read_value = sol_grid[c.point_index][hgss_pkg::VAL_W-1:0];
            queue_word(e);
         end
         default: ;
      endcase
   endfunction

   // drive one word in bursts with random gaps; called at a falling edge
   task automatic push_command(hgss_pkg::req_type c, bit typed = 0, longint rd = 0);
      int idle;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         idle = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         start = 0;
         repeat (idle) @(negedge clock);
      end
      burst_left--;
      start = 1;
      req_data = c;
      do @(posedge clock); while (busy);
      predict_word(c, typed, rd);
      sent++;
      @(negedge clock);
   endtask

   // hold until every result has come and the block is idle
   task automatic drain();
      start = 0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, longint unsigned val, int bits);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      if (bits < 64) junk = (junk >> bits) << bits;
      else junk = 0;
      psel = 1; penable = 0; pwrite = 1;
      paddr = ADR_BITS'(idx) << 3;
      pwdata = val | junk;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
      case (idx)
         hgss_pkg::REG_WIDTH:  width_q = val[hgss_pkg::DIM_W-1:0];
         hgss_pkg::REG_HEIGHT: height_q = val[hgss_pkg::DIM_W-1:0];
         hgss_pkg::REG_ITERS:  iters_q = val[hgss_pkg::ITER_W-1:0];
         hgss_pkg::REG_IHX:    ihx_q = val & 64'hff_ffff_ffff;
         hgss_pkg::REG_IHY:    ihy_q = val & 64'hff_ffff_ffff;
         hgss_pkg::REG_DIAG:   diag_q = val & 64'hff_ffff_ffff;
         hgss_pkg::REG_INVD:   invd_q = val & 64'hffff_ffff;
         default: ;
      endcase
   endtask

   task automatic apply_phase(phase_type p);
      drain();
      csr_write(hgss_pkg::REG_WIDTH, p.w, hgss_pkg::DIM_W);
      csr_write(hgss_pkg::REG_HEIGHT, p.h, hgss_pkg::DIM_W);
      csr_write(hgss_pkg::REG_ITERS, p.it, hgss_pkg::ITER_W);
      csr_write(hgss_pkg::REG_IHX, p.ihx, hgss_pkg::COEF_W);
      csr_write(hgss_pkg::REG_IHY, p.ihy, hgss_pkg::COEF_W);
      csr_write(hgss_pkg::REG_DIAG, p.diag, hgss_pkg::COEF_W);
      csr_write(hgss_pkg::REG_INVD, p.invd, hgss_pkg::INVD_W);
      while (busy) @(negedge clock);
   endtask

   function automatic longint pick_value();
      case ($urandom_range(0, 3))
         0: return longint'($signed({$urandom, $urandom})) >>> 24;
         1: return $urandom_range(0, 1) ? VMAX : VMIN;
         default: return longint'($signed($urandom)) >>> 11;
      endcase
   endfunction

   function automatic bit run_is_safe();
      int size;
      size = width_q * rows_in_use();
      if (width_q < 3 || rows_in_use() < 3 || iters_q == 0) return 1;
      for (int i = 0; i < size; i++) if (!loaded[i]) return 0;
      return 1;
   endfunction

   // random traffic inside one phase
   task automatic random_items(int count);
      hgss_pkg::req_type c;
      int size, pick, tries;
      for (int n = 0; n < count; n++) begin
         size = width_q * rows_in_use();
         c.u_value = VAL_BITS'(pick_value());
         c.f_value = VAL_BITS'(pick_value());
         c.point_index = IDX_BITS'($urandom_range(0, STORE - 1));
         pick = $urandom_range(0, 99);
         if (n == count / 2 && $urandom_range(0, 1)) drain();
         if (pick < 55) begin
            c.operation = hgss_pkg::OP_LOAD;
            if (size > 0 && pick < 45)
               c.point_index = IDX_BITS'($urandom_range(0, size - 1));
         end else if (pick < 85) begin
            c.operation = hgss_pkg::OP_READ;
            tries = 0;
            if (size > 0 && (pick < 78 || size >= STORE))
               do begin
                  c.point_index = IDX_BITS'($urandom_range(0, size - 1));
                  tries++;
               end while (!loaded[c.point_index] && tries < 50);
            else if (size < STORE)
               c.point_index = IDX_BITS'($urandom_range(size, STORE - 1));
            if (c.point_index < size && !loaded[c.point_index]) c.operation = OP_NONE;
         end else if (pick < 93) begin
            c.operation = run_is_safe() ? hgss_pkg::OP_RUN : hgss_pkg::OP_LOAD;
         end else begin
            c.operation = OP_NONE;
         end
         push_command(c);
      end
   endtask

   // check each result against the oldest expectation
   always @(posedge clock) begin
      hgss_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, rsp_data);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.result_kind !== e.result_kind) begin
               $display("%0t: result_kind exp %0d got %0d", $realtime, e.result_kind,
                        rsp_data.result_kind);
               errors++;
            end
            if (rsp_data.read_value !== e.read_value) begin
               $display("%0t: read_value exp %0d got %0d", $realtime, e.read_value,
                        rsp_data.read_value);
               errors++;
            end
            if (rsp_data.residual_sum !== e.residual_sum) begin
               $display("%0t: residual_sum exp %0d got %0d", $realtime, e.residual_sum,
                        rsp_data.residual_sum);
               errors++;
            end
            if (rsp_data.index_error !== e.index_error) begin
               $display("%0t: index_error exp %0d got %0d", $realtime, e.index_error,
                        rsp_data.index_error);
               errors++;
            end
         end
      end
   end

   initial begin
      row_type rows[$];
      phase_type specials[$];
      phase_type p;
      hgss_pkg::req_type c;
      int size, waited;
      errors = 0; sent = 0; burst_left = 0;
      reset = 1; start = 0; req_data = '0;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      width_q = 64; height_q = 64; iters_q = 1;
      ihx_q = 0; ihy_q = 0; diag_q = 0; invd_q = 0; resid_acc = 0;
      foreach (loaded[i]) begin
         loaded[i] = 0; sol_grid[i] = 0; src_grid[i] = 0;
      end
      repeat (9) @(negedge clock);
      reset = 0;

      // directed words under the reset grid of 64 by 64
      rows = '{
         '{hgss_pkg::OP_LOAD, 0, VMAX, VMIN, 0, 0},
         '{hgss_pkg::OP_LOAD, 4095, VMIN, VMAX, 0, 0},
         '{hgss_pkg::OP_LOAD, 1, 0, 0, 0, 0},
         '{OP_NONE, 5, -1, -1, 0, 0},
         '{hgss_pkg::OP_READ, 0, 0, 0, 1, VMAX},
         '{hgss_pkg::OP_READ, 4095, 0, 0, 1, VMIN},
         '{hgss_pkg::OP_READ, 1, 0, 0, 1, 0},
         '{hgss_pkg::OP_LOAD, 2730, 64'h55_5555_5555, -64'sh55_5555_5556, 0, 0},
         '{hgss_pkg::OP_LOAD, 1365, -64'sh55_5555_5556, 64'h55_5555_5555, 0, 0},
         '{hgss_pkg::OP_READ, 2730, 0, 0, 0, 0},
         '{hgss_pkg::OP_READ, 1365, 0, 0, 0, 0}
      };
      foreach (rows[k]) begin
         c.operation = rows[k].op;
         c.point_index = IDX_BITS'(rows[k].idx);
         c.u_value = VAL_BITS'(rows[k].u);
         c.f_value = VAL_BITS'(rows[k].f);
         push_command(c, rows[k].typed, rows[k].rd);
      end

      // extreme settings: no interior, oversized grid, smallest grid at full scale
      specials = '{
         '{0, 0, 65535, 1, 1, 1, 1, 0},
         '{4096, 4096, 65535, 64'hff_ffff_ffff, 0, 64'hff_ffff_ffff, 0, 0},
         '{8191, 8191, 2, 0, 64'hff_ffff_ffff, 0, 64'hffff_ffff, 0},
         '{100, 100, 0, 65536, 65536, 262144, 64'h4000_0000, 0},
         '{3, 3, 1, 64'hff_ffff_ffff, 64'hff_ffff_ffff, 64'hff_ffff_ffff, 64'hffff_ffff, 1},
         '{3, 3, 3, 0, 0, 0, 0, 1},
         '{3, 8191, 1, 65536, 65536, 262144, 64'h4000_0000, 0}
      };
      while (sent < 1800) begin
         if (specials.size() != 0) p = specials.pop_front();
         else begin
            p.w = $urandom_range(3, 7);
            p.h = $urandom_range(3, 7);
            p.it = $urandom_range(0, 3);
            p.ihx = $urandom_range(0, 1 << 20);
            p.ihy = $urandom_range(0, 1 << 20);
            p.diag = 2 * p.ihx + 2 * p.ihy + $urandom_range(0, 1 << 18);
            p.invd = p.diag == 0 ? 64'hffff_ffff : (64'd1 << 48) / p.diag;
            if (p.invd > 64'hffff_ffff) p.invd = 64'hffff_ffff;
            if ($urandom_range(0, 4) == 0) begin
               p.ihx = {$urandom, $urandom} & 64'hff_ffff_ffff;
               p.ihy = {$urandom, $urandom} & 64'hff_ffff_ffff;
               p.diag = {$urandom, $urandom} & 64'hff_ffff_ffff;
               p.invd = $urandom;
            end
            p.full_load = 1;
         end
         apply_phase(p);
         // fill the whole grid so that a run never touches an unwritten point
         if (p.full_load) begin
            size = width_q * rows_in_use();
            for (int i = 0; i < size; i++) begin
               c.operation = hgss_pkg::OP_LOAD;
               c.point_index = IDX_BITS'(i);
               c.u_value = VAL_BITS'(pick_value());
               c.f_value = VAL_BITS'(pick_value());
               push_command(c);
            end
         end
         random_items($urandom_range(30, 70));
      end

      drain();
      waited = 0;
      while (busy && waited < 100000) begin
         @(negedge clock);
         waited++;
      end
      repeat (50) @(negedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
